>>> hdl/circular_list_rotate_delete_top_macros.svh
// ============================================================================
// circular_list_rotate_delete_top_macros.svh
// Assertion macros for the circular list block; empty bodies under SYNTHESIS.
// ============================================================================
`ifndef CIRCULAR_LIST_ROTATE_DELETE_TOP_MACROS_SVH
`define CIRCULAR_LIST_ROTATE_DELETE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// combinational implication, checked every edge out of reset
`define CLRD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("clrd assertion failed");
// implication whose consequent is checked in the next cycle
`define CLRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("clrd assertion failed");
`else
`define CLRD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define CLRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hdl/clrd_pkg.sv
// ============================================================================
// clrd_pkg
// Shared constants, types and slot arithmetic for the circular list block.
// ============================================================================
package clrd_pkg;

    localparam int CAPACITY    = 16;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int COUNT_OUT_W = 5;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_ROT_BACK = 2'd1,
        OP_ROT_FWD  = 2'd2,
        OP_DELETE   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // datapath actions, one per cycle
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INSERT,
        CMD_RD_LAST,
        CMD_RB_WRITE,
        CMD_RD_FRONT,
        CMD_RF_ADV,
        CMD_RF_WRITE,
        CMD_SCAN,
        CMD_COMPACT,
        CMD_DEC,
        CMD_CAP_FRONT,
        CMD_OUT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        logic    set_status;
        t_status status;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic empty;
        logic full;
        logic match;
        logic scan_miss;
        logic compact_done;
        logic out_free;
    } t_dp_sts;

    // ring slot of list position pos (both below CAPACITY)
    function automatic t_idx slot_of(t_idx front, t_cnt pos);
        logic [IDX_W:0] s;
        s = {1'b0, front} + {1'b0, pos[IDX_W-1:0]};
        if (s >= (IDX_W+1)'(CAPACITY)) begin
            s = s - (IDX_W+1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic t_idx prev_slot(t_idx s);
        return (s == '0) ? IDX_W'(CAPACITY - 1) : s - 1'b1;
    endfunction

    function automatic t_idx next_slot(t_idx s);
        return (s == IDX_W'(CAPACITY - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

>>> hdl/clrd_ram.sv
// ============================================================================
// clrd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module clrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/clrd_datapath.sv
// ============================================================================
// clrd_datapath
// Ring store, front/count registers, scan and compaction pointers, result.
// ============================================================================
`include "circular_list_rotate_delete_top_macros.svh"

module clrd_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  clrd_pkg::t_cmd                      i_cmd,
    input  logic [clrd_pkg::OP_W-1:0]           i_operation,
    input  logic signed [clrd_pkg::DATA_W-1:0]  i_value,
    input  logic                                i_stall,
    output clrd_pkg::t_dp_sts                   o_sts,
    output logic                                o_valid,
    output logic [clrd_pkg::ST_W-1:0]           o_status,
    output logic [clrd_pkg::COUNT_OUT_W-1:0]    o_count,
    output logic signed [clrd_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [clrd_pkg::DATA_W-1:0]  o_back_value
);

    // control state
    clrd_pkg::t_idx    r_front;
    clrd_pkg::t_cnt    r_count;
    logic              r_hv;      // read of position r_hpos is in rdata
    logic              r_wv;      // compaction write pending at r_wpos
    logic              r_o_valid;

    // payload
    clrd_pkg::t_op     r_op;
    clrd_pkg::t_data   r_val;
    clrd_pkg::t_cnt    r_pos;
    clrd_pkg::t_cnt    r_hpos;
    clrd_pkg::t_cnt    r_wpos;
    clrd_pkg::t_data   r_tmp;
    clrd_pkg::t_data   r_front_val;
    clrd_pkg::t_status r_status;
    clrd_pkg::t_status r_o_status;
    logic [clrd_pkg::COUNT_OUT_W-1:0] r_o_count;
    clrd_pkg::t_data   r_o_front;
    clrd_pkg::t_data   r_o_back;

    // ram port
    logic                           ram_we;
    clrd_pkg::t_idx                 ram_waddr;
    logic [clrd_pkg::DATA_W-1:0]    ram_wdata;
    logic                           ram_re;
    clrd_pkg::t_idx                 ram_raddr;
    logic [clrd_pkg::DATA_W-1:0]    ram_rdata;
    clrd_pkg::t_data                rdata;

    clrd_pkg::t_cnt cnt_m1;
    clrd_pkg::t_cnt pos_p1;
    logic           empty;
    logic           full;
    logic           match;
    logic           scan_issue;
    logic           comp_issue;
    logic           out_free;
    logic           cmd_ins;
    logic [31:0]    cnt_ext;

    assign rdata      = $signed(ram_rdata);
    assign cnt_m1     = r_count - 1'b1;
    assign pos_p1     = r_pos + 1'b1;
    assign empty      = (r_count == '0);
    assign full       = (r_count == clrd_pkg::CNT_W'(clrd_pkg::CAPACITY));
    assign match      = r_hv && (rdata == r_val);
    assign scan_issue = (r_pos < r_count);
    assign comp_issue = (pos_p1 < r_count);
    assign out_free   = !r_o_valid || !i_stall;
    assign cmd_ins    = (i_cmd.op == clrd_pkg::CMD_INSERT);
    assign cnt_ext    = 32'(r_count);

    assign o_sts.op           = r_op;
    assign o_sts.empty        = empty;
    assign o_sts.full         = full;
    assign o_sts.match        = match;
    assign o_sts.scan_miss    = r_hv && !match && (r_hpos == cnt_m1);
    assign o_sts.compact_done = !r_wv && !comp_issue;
    assign o_sts.out_free     = out_free;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_front;
        ram_wdata = r_val;
        ram_re    = 1'b0;
        ram_raddr = r_front;
        unique case (i_cmd.op)
            clrd_pkg::CMD_INSERT: begin
                ram_we    = 1'b1;
                ram_waddr = clrd_pkg::prev_slot(r_front);
                ram_wdata = r_val;
            end
            clrd_pkg::CMD_RD_LAST, clrd_pkg::CMD_CAP_FRONT: begin
                ram_re    = 1'b1;
                ram_raddr = clrd_pkg::slot_of(r_front, cnt_m1);
            end
            clrd_pkg::CMD_RB_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = clrd_pkg::prev_slot(r_front);
                ram_wdata = ram_rdata;
            end
            clrd_pkg::CMD_RD_FRONT: begin
                ram_re    = 1'b1;
                ram_raddr = r_front;
            end
            clrd_pkg::CMD_RF_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = clrd_pkg::slot_of(r_front, cnt_m1);
                ram_wdata = r_tmp;
            end
            clrd_pkg::CMD_SCAN: begin
                ram_re    = scan_issue;
                ram_raddr = clrd_pkg::slot_of(r_front, r_pos);
            end
            clrd_pkg::CMD_COMPACT: begin
                // read one ahead, write the previous read one place forward
                ram_re    = comp_issue;
                ram_raddr = clrd_pkg::slot_of(r_front, pos_p1);
                ram_we    = r_wv;
                ram_waddr = clrd_pkg::slot_of(r_front, r_wpos);
                ram_wdata = ram_rdata;
            end
            default: begin
            end
        endcase
    end

    clrd_ram #(
        .WIDTH (clrd_pkg::DATA_W),
        .DEPTH (clrd_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_count   <= '0;
            r_hv      <= 1'b0;
            r_wv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // a new result replaces the one taken in the same cycle
            if (i_cmd.op == clrd_pkg::CMD_OUT) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                clrd_pkg::CMD_LOAD: begin
                    r_hv <= 1'b0;
                    r_wv <= 1'b0;
                end
                clrd_pkg::CMD_INSERT: begin
                    r_front <= clrd_pkg::prev_slot(r_front);
                    r_count <= r_count + 1'b1;
                end
                clrd_pkg::CMD_RB_WRITE: r_front <= clrd_pkg::prev_slot(r_front);
                clrd_pkg::CMD_RF_ADV:   r_front <= clrd_pkg::next_slot(r_front);
                clrd_pkg::CMD_SCAN: begin
                    if (match) begin
                        r_hv <= 1'b0;
                        r_wv <= 1'b0;
                    end else begin
                        r_hv <= scan_issue;
                    end
                end
                clrd_pkg::CMD_COMPACT: r_wv      <= comp_issue;
                clrd_pkg::CMD_DEC:     r_count   <= r_count - 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        unique case (i_cmd.op)
            clrd_pkg::CMD_LOAD: begin
                r_op  <= clrd_pkg::t_op'(i_operation);
                r_val <= i_value;
                r_pos <= '0;
            end
            clrd_pkg::CMD_SCAN: begin
                if (match) begin
                    r_pos <= r_hpos;      // compaction starts at the hit
                end else if (scan_issue) begin
                    r_hpos <= r_pos;
                    r_pos  <= pos_p1;
                end
            end
            clrd_pkg::CMD_COMPACT: begin
                if (comp_issue) begin
                    r_wpos <= r_pos;
                    r_pos  <= pos_p1;
                end
            end
            clrd_pkg::CMD_RF_ADV:    r_tmp       <= rdata;
            clrd_pkg::CMD_CAP_FRONT: r_front_val <= rdata;
            clrd_pkg::CMD_OUT: begin
                r_o_status <= r_status;
                r_o_count  <= cnt_ext[clrd_pkg::COUNT_OUT_W-1:0];
                r_o_front  <= empty ? '0 : r_front_val;
                r_o_back   <= empty ? '0 : rdata;
            end
            default: begin
            end
        endcase
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_count       = r_o_count;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;

    `CLRD_ASSERT_IMPLY(a_ins_not_full, i_clk, i_rst_n, cmd_ins, !full)
    `CLRD_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, cmd_ins, r_count == $past(r_count) + 1'b1)
    `CLRD_ASSERT_IMPLY(a_dec_not_empty, i_clk, i_rst_n, i_cmd.op == clrd_pkg::CMD_DEC, !empty)
    `CLRD_ASSERT_IMPLY(a_out_free, i_clk, i_rst_n, i_cmd.op == clrd_pkg::CMD_OUT, out_free)

endmodule

>>> hdl/clrd_ctrl.sv
// ============================================================================
// clrd_ctrl
// Sequencer: decodes the operation and steps the datapath through it.
// ============================================================================
module clrd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  clrd_pkg::t_dp_sts i_sts,
    output clrd_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b00000000001,
        S_DECODE    = 11'b00000000010,
        S_RB_WRITE  = 11'b00000000100,
        S_RF_ADV    = 11'b00000001000,
        S_RF_WRITE  = 11'b00000010000,
        S_SCAN      = 11'b00000100000,
        S_COMPACT   = 11'b00001000000,
        S_RD_FRONT  = 11'b00010000000,
        S_CAP_FRONT = 11'b00100000000,
        S_OUT       = 11'b01000000000,
        S_SPARE     = 11'b10000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.op         = clrd_pkg::CMD_NONE;
        o_cmd.set_status = 1'b0;
        o_cmd.status     = clrd_pkg::ST_OK;
        o_busy           = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_valid) begin
                    o_cmd.op = clrd_pkg::CMD_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                priority if (i_sts.op == clrd_pkg::OP_INSERT) begin
                    if (i_sts.full) begin
                        o_cmd.status = clrd_pkg::ST_FULL;
                    end else begin
                        o_cmd.op = clrd_pkg::CMD_INSERT;
                    end
                    n_state = S_RD_FRONT;
                end else if (i_sts.empty) begin
                    o_cmd.status = clrd_pkg::ST_EMPTY;
                    n_state      = S_OUT;
                end else if (i_sts.op == clrd_pkg::OP_ROT_BACK) begin
                    o_cmd.op = clrd_pkg::CMD_RD_LAST;
                    n_state  = S_RB_WRITE;
                end else if (i_sts.op == clrd_pkg::OP_ROT_FWD) begin
                    o_cmd.op = clrd_pkg::CMD_RD_FRONT;
                    n_state  = S_RF_ADV;
                end else begin
                    o_cmd.op = clrd_pkg::CMD_SCAN;
                    n_state  = S_SCAN;
                end
            end
            S_RB_WRITE: begin
                o_cmd.op = clrd_pkg::CMD_RB_WRITE;
                n_state  = S_RD_FRONT;
            end
            S_RF_ADV: begin
                o_cmd.op = clrd_pkg::CMD_RF_ADV;
                n_state  = S_RF_WRITE;
            end
            S_RF_WRITE: begin
                o_cmd.op = clrd_pkg::CMD_RF_WRITE;
                n_state  = S_RD_FRONT;
            end
            S_SCAN: begin
                o_cmd.op = clrd_pkg::CMD_SCAN;
                priority if (i_sts.match) begin
                    n_state = S_COMPACT;
                end else if (i_sts.scan_miss) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = clrd_pkg::ST_NOT_FOUND;
                    n_state          = S_RD_FRONT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_COMPACT: begin
                if (i_sts.compact_done) begin
                    o_cmd.op = clrd_pkg::CMD_DEC;
                    n_state  = S_RD_FRONT;
                end else begin
                    o_cmd.op = clrd_pkg::CMD_COMPACT;
                end
            end
            S_RD_FRONT: begin
                if (i_sts.empty) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = clrd_pkg::CMD_RD_FRONT;
                    n_state  = S_CAP_FRONT;
                end
            end
            S_CAP_FRONT: begin
                o_cmd.op = clrd_pkg::CMD_CAP_FRONT;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = clrd_pkg::CMD_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/circular_list_rotate_delete_top.sv
// A result still stalled at the output holds the next result back until it is taken.
// One item at a time: the next item is taken the cycle after the result is registered.
// Reset (i_rst_n low, synchronous): list empty, front slot zero, no result pending.
// ============================================================================
// circular_list_rotate_delete_top
// Bounded circular list of signed 32-bit values with insert-front, rotations
// and order-preserving delete; one result item per input item.
// ============================================================================
//
// Structure
//   clrd_ctrl     - one-hot sequencer, issues one datapath command per cycle
//   clrd_datapath - ring store (clrd_ram), front index, count, scan and
//                   compaction pointers, output register
//
// The ring store is addressed from the front index. Delete runs a pipelined
// scan from the front (read next slot while comparing the previous one),
// then a pipelined compaction that moves each later value one place toward
// the front. Every item that leaves the list non-empty ends with a read of the front and back slots.
//
// Handshake
//   input  item: accepted when i_valid && !o_stall
//   output item: taken when o_valid && !i_stall; the result stays in the
//                output register while the next item is already accepted.
// ============================================================================
module circular_list_rotate_delete_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [clrd_pkg::OP_W-1:0]           i_operation,
    input  logic signed [clrd_pkg::DATA_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [clrd_pkg::ST_W-1:0]           o_status,
    output logic [clrd_pkg::COUNT_OUT_W-1:0]    o_count,
    output logic signed [clrd_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [clrd_pkg::DATA_W-1:0]  o_back_value
);

    clrd_pkg::t_cmd    cmd;
    clrd_pkg::t_dp_sts sts;
    logic              busy;

    // sequencer: busy whenever an item is in flight
    clrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    clrd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_stall       (i_stall),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_count       (o_count),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value)
    );

    // input side is held off while an item is being worked on
    assign o_stall = busy;

endmodule
